/* rtl/mnli_pkg.sv */
// ----------------------------------------------------------------------------
// mnli_pkg
// Shared types and codes for the MIDI note LED indicator: message word,
// configuration registers, command and channel-mode codes.
// ----------------------------------------------------------------------------
package mnli_pkg;

  // Field widths of the message and result words
  localparam int CMD_W     = 2;
  localparam int CHAN_W    = 4;
  localparam int MIDI_W    = 7;
  localparam int PATTERN_W = 6;

  // Largest MIDI data byte, and the number of distinct data values
  localparam int DATA_MAX  = 127;
  localparam int MIDI_SPAN = 128;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CC       = 2'd2;

  // Channels with a special note mode
  localparam logic [CHAN_W-1:0] CHAN_MODULO = 4'd1;
  localparam logic [CHAN_W-1:0] CHAN_HOLD   = 4'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_NOTE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CTRL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY   = 2'd2;

  // Configuration reset values
  localparam logic [MIDI_W-1:0] ROOT_NOTE_RST = 7'd60;
  localparam logic [MIDI_W-1:0] BASE_CTRL_RST = 7'd0;
  localparam logic              PRIORITY_RST  = 1'b1;

  // One MIDI message word
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAN_W-1:0] channel;
    logic [MIDI_W-1:0] number;
    logic [MIDI_W-1:0] value;
  } msg_t;

  // Configuration register set
  typedef struct packed {
    logic [MIDI_W-1:0] root_note;
    logic [MIDI_W-1:0] base_controller;
    logic              indicator_priority;
  } cfg_t;

endpackage

/* rtl/mnli_if.sv */
// ----------------------------------------------------------------------------
// mnli_if
// Valid/ready channels of the MIDI note LED indicator: the message channel
// and the LED pattern channel.
// ----------------------------------------------------------------------------
interface mnli_msg_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] channel;
  logic [6:0] number;
  logic [6:0] value;

  modport source (output valid, output command, output channel, output number,
                  output value, input ready);
  modport sink   (input valid, input command, input channel, input number,
                  input value, output ready);
endinterface

interface mnli_led_if;
  logic       valid;
  logic       ready;
  logic [5:0] led_pattern;

  modport source (output valid, output led_pattern, input ready);
  modport sink   (input valid, input led_pattern, output ready);
endinterface

/* rtl/mnli_update.sv */
// ----------------------------------------------------------------------------
// mnli_update
// Next-state logic of the LED bank: applies one message word to the LED
// states, the indicator flag and the indicator LED index.
// ----------------------------------------------------------------------------
module mnli_update
  import mnli_pkg::*;
#(
  parameter int NUM_LEDS = 6
) (
  input  msg_t                          msg,
  input  cfg_t                          cfg,
  input  logic [NUM_LEDS-1:0]           led_q,
  input  logic                          cc_seen_q,
  input  logic [$clog2(NUM_LEDS)-1:0]   ind_q,
  output logic [NUM_LEDS-1:0]           led_d,
  output logic                          cc_seen_d,
  output logic [$clog2(NUM_LEDS)-1:0]   ind_d
);

  localparam int IW = $clog2(NUM_LEDS);
  localparam logic [NUM_LEDS-1:0] ONE_HOT0 = NUM_LEDS'(1);

  // Constant tables over every 7-bit data value
  logic [IW-1:0] mod_tbl [MIDI_SPAN];
  logic [IW-1:0] idx_tbl [MIDI_SPAN];

  for (genvar g = 0; g < MIDI_SPAN; g++) begin : g_tbl
    localparam int RAW = ((NUM_LEDS - 1) * g + 2 * (DATA_MAX / (NUM_LEDS - 1)))
                         / DATA_MAX;
    localparam int SAT = (RAW > NUM_LEDS - 1) ? NUM_LEDS - 1 : RAW;
    assign mod_tbl[g] = IW'(g % NUM_LEDS);
    assign idx_tbl[g] = IW'(SAT);
  end

  logic              is_note;
  logic              note_on;
  logic [MIDI_W-1:0] diff;
  logic              in_range;
  logic              have;
  logic              clr_all;
  logic [IW-1:0]     offs;
  logic              protect;
  logic [NUM_LEDS-1:0] base;
  logic [NUM_LEDS-1:0] bit_mask;
  logic [IW-1:0]     cc_idx;

  // Map the note to an LED offset by channel mode
  always_comb begin
    is_note  = (msg.command == CMD_NOTE_OFF) || (msg.command == CMD_NOTE_ON);
    note_on  = (msg.command == CMD_NOTE_ON);
    diff     = msg.number - cfg.root_note;
    in_range = (msg.number >= cfg.root_note) && (diff < MIDI_W'(NUM_LEDS));
    have     = 1'b0;
    clr_all  = 1'b0;
    offs     = diff[IW-1:0];
    priority if (msg.channel == CHAN_MODULO) begin
      offs = mod_tbl[msg.number];
      have = 1'b1;
    end else if (msg.channel == CHAN_HOLD) begin
      have    = note_on && in_range;
      clr_all = note_on && in_range;
    end else begin
      have = in_range;
    end
  end

  // Apply the word to the state
  always_comb begin
    protect  = cfg.indicator_priority && cc_seen_q && (offs == ind_q);
    base     = clr_all ? '0 : led_q;
    bit_mask = ONE_HOT0 << offs;
    cc_idx   = idx_tbl[msg.value];
    led_d     = led_q;
    cc_seen_d = cc_seen_q;
    ind_d     = ind_q;
    if (is_note) begin
      led_d = base;
      if (have && !protect) begin
        led_d = note_on ? (base | bit_mask) : (base & ~bit_mask);
      end
    end else if ((msg.command == CMD_CC) && (msg.number == cfg.base_controller)) begin
      led_d     = ONE_HOT0 << cc_idx;
      cc_seen_d = 1'b1;
      ind_d     = cc_idx;
    end
  end

endmodule

/* rtl/midi_note_led_indicator.sv */
// ----------------------------------------------------------------------------
// midi_note_led_indicator
// Keeps a bank of LED states driven by MIDI note and control-change words.
// ----------------------------------------------------------------------------
// Every accepted message word gives exactly one LED pattern word. A word is
// taken into an input register, the LED state is updated from it when it
// leaves that register while the pattern goes into the output register, and
// one word per cycle is sustained while out_led.ready stays high; the limit
// is the read-modify-write of the LED state. Channel 1 maps notes modulo
// NUM_LEDS, channel 2 holds a single LED, other channels map notes from the
// root note register. A control change on base_controller lights one
// indicator LED, which notes other than channel 2 note-ons leave alone while
// indicator_priority is set. Write configuration registers only while no
// word is in flight. Reset: all LEDs off, no indicator, root note 60,
// base_controller 0, priority on.
// ----------------------------------------------------------------------------
module midi_note_led_indicator
  import mnli_pkg::*;
#(
  parameter int NUM_LEDS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mnli_msg_if.sink              in_msg,
  mnli_led_if.source            out_led,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = $clog2(NUM_LEDS);

  cfg_t                cfg_r;
  logic                s1_vld_r;
  msg_t                msg_r;
  logic [NUM_LEDS-1:0] led_r;
  logic [NUM_LEDS-1:0] led_nxt;
  logic                cc_seen_r;
  logic                cc_seen_nxt;
  logic [IW-1:0]       ind_r;
  logic [IW-1:0]       ind_nxt;
  logic                out_vld_r;
  logic [PATTERN_W-1:0] pat_r;
  logic [PATTERN_W-1:0] pat_nxt;
  logic                out_adv;
  logic                s1_adv;
  logic                in_acc;

  // Handshake: output register frees when empty or taken
  assign out_adv      = !out_vld_r || out_led.ready;
  assign s1_adv       = s1_vld_r && out_adv;
  assign in_msg.ready = !s1_vld_r || out_adv;
  assign in_acc       = in_msg.valid && in_msg.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.root_note          <= ROOT_NOTE_RST;
      cfg_r.base_controller    <= BASE_CTRL_RST;
      cfg_r.indicator_priority <= PRIORITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROOT_NOTE: cfg_r.root_note          <= cfg_data[MIDI_W-1:0];
        REG_BASE_CTRL: cfg_r.base_controller    <= cfg_data[MIDI_W-1:0];
        REG_PRIORITY:  cfg_r.indicator_priority <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: hold the word until the update stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      msg_r.command <= in_msg.command;
      msg_r.channel <= in_msg.channel;
      msg_r.number  <= in_msg.number;
      msg_r.value   <= in_msg.value;
    end
  end

  mnli_update #(
    .NUM_LEDS (NUM_LEDS)
  ) u_update (
    .msg       (msg_r),
    .cfg       (cfg_r),
    .led_q     (led_r),
    .cc_seen_q (cc_seen_r),
    .ind_q     (ind_r),
    .led_d     (led_nxt),
    .cc_seen_d (cc_seen_nxt),
    .ind_d     (ind_nxt)
  );

  // Show the low LEDs on the pattern word, zero above the bank
  for (genvar i = 0; i < PATTERN_W; i++) begin : g_pat
    if (i < NUM_LEDS) begin : g_led
      assign pat_nxt[i] = led_nxt[i];
    end else begin : g_none
      assign pat_nxt[i] = 1'b0;
    end
  end

  // LED state: advance once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r     <= '0;
      cc_seen_r <= 1'b0;
      ind_r     <= '0;
    end else if (s1_adv) begin
      led_r     <= led_nxt;
      cc_seen_r <= cc_seen_nxt;
      ind_r     <= ind_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_led.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pat_r <= pat_nxt;
    end
  end

  assign out_led.valid       = out_vld_r;
  assign out_led.led_pattern = pat_r;

endmodule
